### rtl/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPL(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");

`define CHK_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");

`endif

### rtl/bsrq_pkg.sv
package bsrq_pkg;

    typedef enum logic [2:0] {
        OP_PUT   = 3'd0,
        OP_RX    = 3'd1,
        OP_TXRDY = 3'd2,
        OP_GET   = 3'd3,
        OP_CLR   = 3'd4
    } t_op;

    localparam logic [7:0] CH_ESC = 8'h1B;
    localparam logic [7:0] CH_LBR = 8'h5B;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // request passed from front to back
    typedef struct packed {
        logic [2:0] op;
        logic [7:0] data;
        logic       echo;
    } t_req;

endpackage

### rtl/bsrq_front.sv
module bsrq_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_data,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2:0]      i_operation,
    input  logic [7:0]      i_data_byte,
    output logic            o_q_valid,
    input  logic            i_q_ready,
    output bsrq_pkg::t_req  o_q_req
);
    import bsrq_pkg::*;

    logic r_echo;
    // two-entry request queue
    t_req       r_q [2];
    logic       r_rd, r_wr;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign pop       = o_q_valid && i_q_ready;
    assign o_q_req   = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo <= 1'b0;
            r_rd   <= 1'b0;
            r_wr   <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_cfg_we) r_echo <= i_cfg_data;
            if (push) r_wr <= ~r_wr;
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr].op   <= i_operation;
            r_q[r_wr].data <= i_data_byte;
            r_q[r_wr].echo <= r_echo;
        end
    end
endmodule

### rtl/bsrq_back.sv
module bsrq_back #(
    parameter int TX_DEPTH = 256,
    parameter int RX_DEPTH = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    output logic           o_q_ready,
    input  bsrq_pkg::t_req i_q_req,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_tx_valid,
    output logic [7:0]     o_tx_byte,
    output logic           o_read_valid,
    output logic [7:0]     o_read_byte,
    output logic           o_put_dropped,
    output logic           o_rx_nonempty,
    output logic           o_overrun_flag,
    output logic           o_tx_active,
    output logic [8:0]     o_tx_fill,
    output logic [4:0]     o_rx_fill
);
    import bsrq_pkg::*;

    localparam int TAW = $clog2(TX_DEPTH);
    localparam int RAW = $clog2(RX_DEPTH);
    localparam int TCW = $clog2(TX_DEPTH + 1);
    localparam int RCW = $clog2(RX_DEPTH + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_WR2  = 4'b0010,
        S_RD   = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [7:0]     r_tx_mem [TX_DEPTH];
    logic [7:0]     r_rx_mem [RX_DEPTH];
    logic [TAW-1:0] r_tx_wr, r_tx_rd;
    logic [RAW-1:0] r_rx_wr, r_rx_rd;
    logic [TCW-1:0] r_tx_cnt;
    logic [RCW-1:0] r_rx_cnt;
    logic           r_ovr, r_txen;
    logic [7:0]     r_older, r_newer;
    t_req           r_req;
    logic [7:0]     r_tx_q, r_rx_q;
    logic           r_txv, r_rdv, r_drop;
    logic           r_busy, r_echo_blk;

    logic           tx_full, rx_full;
    logic           do_push, push_byte_lf, out_load;
    logic [7:0]     push_byte, rx_st, mapped;

    function automatic logic [TAW-1:0] tinc(input logic [TAW-1:0] a);
        tinc = (a == TAW'(TX_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction
    function automatic logic [RAW-1:0] rinc(input logic [RAW-1:0] a);
        rinc = (a == RAW'(RX_DEPTH - 1)) ? '0 : a + 1'b1;
    endfunction

    assign tx_full   = (r_tx_cnt == TCW'(TX_DEPTH));
    assign rx_full   = (r_rx_cnt == RCW'(RX_DEPTH));
    assign o_q_ready = (r_state == S_IDLE) && !r_busy;
    assign out_load  = (r_state == S_OUT) && (!o_valid || i_ready);
    assign rx_st     = (r_req.data == CH_CR) ? CH_LF : r_req.data;
    // S_IDLE writes CR for an LF put or an echoed LF receive, S_WR2 writes the byte itself
    assign push_byte_lf = (r_req.data == CH_LF);
    assign push_byte    = (r_state == S_IDLE && push_byte_lf) ? CH_CR : r_req.data;

    always_comb begin
        mapped = r_rx_q;
        if (r_older == CH_ESC && r_newer == CH_LBR) begin
            unique case (r_rx_q)
                8'h41:   mapped = 8'h77;
                8'h42:   mapped = 8'h73;
                8'h43:   mapped = 8'h64;
                8'h44:   mapped = 8'h61;
                default: mapped = r_rx_q;
            endcase
        end
    end

    // items load into r_req on accept, then run through S_IDLE, S_WR2 (puts and echoed receives only), S_RD and S_OUT
    always_comb begin
        n_state = r_state;
        do_push = 1'b0;
        unique case (r_state)
            S_IDLE: if (r_busy) begin
                if (r_req.op == OP_PUT || (r_req.op == OP_RX && r_req.echo)) begin
                    do_push = push_byte_lf;
                    n_state = S_WR2;
                end else begin
                    n_state = S_RD;
                end
            end
            S_WR2:   begin do_push = 1'b1; n_state = S_RD; end
            S_RD:    n_state = S_OUT;
            S_OUT:   if (!o_valid || i_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (do_push && !tx_full) r_tx_mem[r_tx_wr] <= push_byte;
        if (r_state == S_RD && r_req.op == OP_RX && !rx_full) r_rx_mem[r_rx_wr] <= rx_st;
        if (r_state == S_RD) begin
            r_tx_q <= r_tx_mem[r_tx_rd];
            r_rx_q <= r_rx_mem[r_rx_rd];
        end
        if (i_q_valid && o_q_ready) r_req <= i_q_req;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_busy <= 1'b0; o_valid <= 1'b0;
            r_tx_wr <= '0; r_tx_rd <= '0; r_tx_cnt <= '0;
            r_rx_wr <= '0; r_rx_rd <= '0; r_rx_cnt <= '0;
            r_ovr <= 1'b0; r_txen <= 1'b0; r_older <= '0; r_newer <= '0;
            r_txv <= 1'b0; r_rdv <= 1'b0; r_drop <= 1'b0; r_echo_blk <= 1'b0;
            o_tx_valid <= 1'b0; o_tx_byte <= '0; o_read_valid <= 1'b0;
            o_read_byte <= '0; o_put_dropped <= 1'b0; o_rx_nonempty <= 1'b0;
            o_overrun_flag <= 1'b0; o_tx_active <= 1'b0;
            o_tx_fill <= '0; o_rx_fill <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) o_valid <= 1'b1;
            else if (o_valid && i_ready) o_valid <= 1'b0;
            if (r_state == S_IDLE && !r_busy && i_q_valid) r_busy <= 1'b1;
            if (r_state == S_IDLE && r_busy) begin
                r_txv <= 1'b0; r_rdv <= 1'b0;
                // echo is skipped entirely if the tx queue is full when the request is classified
                r_echo_blk <= (r_req.op == OP_RX) && tx_full;
                r_drop <= (r_req.op == OP_RX && tx_full && r_req.echo) ||
                          (do_push && tx_full);
            end else if (do_push && !r_echo_blk && tx_full) begin
                r_drop <= 1'b1;
            end
            if (do_push && !(r_state == S_WR2 && r_echo_blk) && !tx_full) begin
                r_tx_wr <= tinc(r_tx_wr);
                r_tx_cnt <= r_tx_cnt + 1'b1;
                r_txen <= 1'b1;
            end
            if (r_state == S_RD) begin
                unique case (r_req.op)
                    OP_RX: begin
                        if (rx_full) r_ovr <= 1'b1;
                        else begin
                            r_rx_wr <= rinc(r_rx_wr);
                            r_rx_cnt <= r_rx_cnt + 1'b1;
                        end
                    end
                    OP_TXRDY: begin
                        if (r_tx_cnt != '0) begin
                            r_txv <= 1'b1;
                            r_tx_rd <= tinc(r_tx_rd);
                            r_tx_cnt <= r_tx_cnt - 1'b1;
                        end else r_txen <= 1'b0;
                    end
                    OP_GET: begin
                        if (r_rx_cnt != '0) begin
                            r_rdv <= 1'b1;
                            r_rx_rd <= rinc(r_rx_rd);
                            r_rx_cnt <= r_rx_cnt - 1'b1;
                        end
                    end
                    OP_CLR: begin
                        r_rx_wr <= '0; r_rx_rd <= '0; r_rx_cnt <= '0;
                    end
                    default: ;
                endcase
            end
            // S_OUT waits only until the output register is free
            if (out_load) begin
                r_busy         <= 1'b0;
                o_tx_valid     <= r_txv;
                o_tx_byte      <= r_txv ? r_tx_q : 8'd0;
                o_read_valid   <= r_rdv;
                o_read_byte    <= r_rdv ? mapped : 8'd0;
                o_put_dropped  <= r_drop;
                o_rx_nonempty  <= (r_rx_cnt != '0);
                o_overrun_flag <= r_ovr;
                o_tx_active    <= r_txen;
                o_tx_fill      <= 9'(r_tx_cnt);
                o_rx_fill      <= 5'(r_rx_cnt);
                if (r_rdv) begin
                    r_older <= r_newer;
                    r_newer <= mapped;
                end
            end
        end
    end
endmodule

### rtl/buffered_serial_rx_tx_queues.sv
// each request runs through the back-end sequencer in order: load, classify with CR push,
// second push (puts and echoed receives only), queue read, result load; the back end takes
// a new request only after the result of the last one has loaded into the output register
// a two-entry request queue lets the input side run ahead of the back end
// i_rst_n synchronous active low: queues empty, flags and history cleared, echo off
module buffered_serial_rx_tx_queues #(
    parameter int TX_DEPTH = 256,
    parameter int RX_DEPTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [2:0] i_operation,
    input  logic [7:0] i_data_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic       o_tx_valid,
    output logic [7:0] o_tx_byte,
    output logic       o_read_valid,
    output logic [7:0] o_read_byte,
    output logic       o_put_dropped,
    output logic       o_rx_nonempty,
    output logic       o_overrun_flag,
    output logic       o_tx_active,
    output logic [8:0] o_tx_fill,
    output logic [4:0] o_rx_fill
);
    import bsrq_pkg::*;

    logic q_valid, q_ready;
    t_req q_req;

    bsrq_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_data, .i_valid, .o_ready,
        .i_operation, .i_data_byte,
        .o_q_valid(q_valid), .i_q_ready(q_ready), .o_q_req(q_req)
    );

    bsrq_back #(.TX_DEPTH(TX_DEPTH), .RX_DEPTH(RX_DEPTH)) u_back (
        .i_clk, .i_rst_n,
        .i_q_valid(q_valid), .o_q_ready(q_ready), .i_q_req(q_req),
        .o_valid, .i_ready, .o_tx_valid, .o_tx_byte, .o_read_valid, .o_read_byte,
        .o_put_dropped, .o_rx_nonempty, .o_overrun_flag, .o_tx_active,
        .o_tx_fill, .o_rx_fill
    );
endmodule

### rtl/bsrq_checker.sv
`include "assert_macros.svh"
module bsrq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic       o_tx_valid,
    input logic       o_read_valid,
    input logic       o_overrun_flag,
    input logic       o_rx_nonempty,
    input logic [4:0] o_rx_fill,
    input logic [8:0] o_tx_fill
);
    `CHK_IMPL(a_avail, i_clk, i_rst_n, o_valid, o_rx_nonempty == (o_rx_fill != 5'd0))
    `CHK_IMPL(a_excl, i_clk, i_rst_n, o_valid, !(o_tx_valid && o_read_valid))
    `CHK_NEXT(a_sticky, i_clk, i_rst_n, o_overrun_flag, o_overrun_flag)
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_tx_fill))
endmodule

bind buffered_serial_rx_tx_queues bsrq_checker u_chk (
    .i_clk, .i_rst_n, .o_valid, .i_ready, .o_tx_valid, .o_read_valid,
    .o_overrun_flag, .o_rx_nonempty, .o_rx_fill, .o_tx_fill
);

### tb/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bsrq_pkg::*;

    localparam int TXD = 256;
    localparam int RXD = 16;
    localparam int HOLD_LEN = 300;
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       put_dropped;
        logic       rx_nonempty;
        logic       overrun_flag;
        logic       tx_active;
        logic [8:0] tx_fill;
        logic [4:0] rx_fill;
    } t_status;

    logic       i_clk = 0;
    logic       i_rst_n = 0;
    logic       i_cfg_we = 0;
    logic       i_cfg_data = 0;
    logic       i_valid = 0;
    logic       o_ready;
    logic [2:0] i_operation = 0;
    logic [7:0] i_data_byte = 0;
    logic       o_valid;
    logic       i_ready = 0;
    logic       o_tx_valid;
    logic [7:0] o_tx_byte;
    logic       o_read_valid;
    logic [7:0] o_read_byte;
    logic       o_put_dropped;
    logic       o_rx_nonempty;
    logic       o_overrun_flag;
    logic       o_tx_active;
    logic [8:0] o_tx_fill;
    logic [4:0] o_rx_fill;

    buffered_serial_rx_tx_queues dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // mirror of the block's queues and flags
    logic [7:0] tx_q[$];
    logic [7:0] rx_q[$];
    logic       m_overrun, m_tx_en, m_echo;
    logic [7:0] m_older, m_newer;
    t_status    expected_status[$];
    int         errors = 0;
    int         send_idle = 0, recv_idle = 0;
    logic       hold_req = 0;
    int         hold_left = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic logic push_tx(input logic [7:0] b);
        if (tx_q.size() >= TXD) return 1;
        tx_q.push_back(b);
        m_tx_en = 1;
        return 0;
    endfunction

    function automatic logic put_tx(input logic [7:0] b);
        logic lost;
        lost = 0;
        if (b == CH_LF) lost = push_tx(CH_CR);
        lost |= push_tx(b);
        return lost;
    endfunction

    function automatic t_status predict_status(input logic [2:0] op, input logic [7:0] b);
        t_status s;
        logic [7:0] c;
        s = '0;
        case (op)
            OP_PUT: s.put_dropped = put_tx(b);
            OP_RX: begin
                if (m_echo) s.put_dropped = (tx_q.size() < TXD) ? put_tx(b) : 1'b1;
                if (rx_q.size() >= RXD) m_overrun = 1;
                else rx_q.push_back(b == CH_CR ? CH_LF : b);
            end
            OP_TXRDY: begin
                if (tx_q.size() > 0) begin
                    s.tx_valid = 1;
                    s.tx_byte = tx_q.pop_front();
                end else m_tx_en = 0;
            end
            OP_GET: begin
                if (rx_q.size() > 0) begin
                    c = rx_q.pop_front();
                    if (m_older == CH_ESC && m_newer == CH_LBR) begin
                        if (c == "A") c = "w";
                        else if (c == "B") c = "s";
                        else if (c == "C") c = "d";
                        else if (c == "D") c = "a";
                    end
                    m_older = m_newer;
                    m_newer = c;
                    s.read_valid = 1;
                    s.read_byte = c;
                end
            end
            OP_CLR: rx_q.delete();
            default: ;
        endcase
        s.rx_nonempty = rx_q.size() != 0;
        s.overrun_flag = m_overrun;
        s.tx_active = m_tx_en;
        s.tx_fill = 9'(tx_q.size());
        s.rx_fill = 5'(rx_q.size());
        return s;
    endfunction

    task automatic send_request(input logic [2:0] op, input logic [7:0] b);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 0;
            @(negedge i_clk);
        end
        i_valid <= 1;
        i_operation <= op;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_status.push_back(predict_status(op, b));
        @(negedge i_clk);
    endtask

    // receiver with random stalls and an optional long hold-off
    always @(negedge i_clk) begin
        if (hold_req) begin
            i_ready <= 0;
            hold_left <= HOLD_LEN;
        end else if (hold_left > 0) begin
            i_ready <= 0;
            hold_left <= hold_left - 1;
        end else i_ready <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_status w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_status.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                w = expected_status.pop_front();
                if (o_tx_valid !== w.tx_valid) report_mismatch("tx_valid", o_tx_valid, w.tx_valid);
                if (o_tx_byte !== w.tx_byte) report_mismatch("tx_byte", o_tx_byte, w.tx_byte);
                if (o_read_valid !== w.read_valid)
                    report_mismatch("read_valid", o_read_valid, w.read_valid);
                if (o_read_byte !== w.read_byte)
                    report_mismatch("read_byte", o_read_byte, w.read_byte);
                if (o_put_dropped !== w.put_dropped)
                    report_mismatch("put_dropped", o_put_dropped, w.put_dropped);
                if (o_rx_nonempty !== w.rx_nonempty)
                    report_mismatch("rx_nonempty", o_rx_nonempty, w.rx_nonempty);
                if (o_overrun_flag !== w.overrun_flag)
                    report_mismatch("overrun_flag", o_overrun_flag, w.overrun_flag);
                if (o_tx_active !== w.tx_active)
                    report_mismatch("tx_active", o_tx_active, w.tx_active);
                if (o_tx_fill !== w.tx_fill) report_mismatch("tx_fill", o_tx_fill, w.tx_fill);
                if (o_rx_fill !== w.rx_fill) report_mismatch("rx_fill", o_rx_fill, w.rx_fill);
            end
        end
    end

    task automatic drain_and_settle();
        i_valid <= 0;
        while (expected_status.size() != 0) @(negedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    task automatic set_echo(input logic v);
        drain_and_settle();
        i_cfg_we <= 1;
        i_cfg_data <= v;
        m_echo = v;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic test_directed();
        send_request(OP_GET, 8'h00);
        send_request(OP_TXRDY, 8'h00);
        send_request(OP_PUT, CH_LF);
        send_request(OP_PUT, 8'hFF);
        send_request(OP_PUT, 8'h00);
        for (int i = 0; i < 4; i++) send_request(OP_TXRDY, 8'h00);
        send_request(OP_RX, CH_CR);
        send_request(OP_RX, CH_ESC);
        send_request(OP_RX, CH_LBR);
        send_request(OP_RX, "A");
        send_request(OP_RX, 8'hFF);
        for (int i = 0; i < 5; i++) send_request(OP_GET, 8'h00);
        send_request(OP_CLR, 8'h00);
        send_request(OP_UNUSED_LO, 8'h55);
        send_request(OP_UNUSED_HI, 8'hAA);
    endtask

    task automatic test_echo_escape();
        logic [7:0] arrows[4] = '{"A", "B", "C", "D"};
        set_echo(1);
        for (int i = 0; i < 10; i++) begin
            send_request(OP_RX, CH_ESC);
            send_request(OP_RX, CH_LBR);
            send_request(OP_RX, ($urandom_range(3) == 0) ? 8'($urandom) : arrows[$urandom_range(3)]);
            for (int k = 0; k < 3; k++) send_request(OP_GET, 8'h00);
            if ($urandom_range(1)) send_request(OP_RX, ($urandom_range(1)) ? CH_CR : CH_LF);
            repeat (4) send_request(OP_TXRDY, 8'h00);
        end
    endtask

    task automatic test_full_queues();
        // fill tx to capacity and beyond with echo off, then overflow rx with echo on
        set_echo(0);
        for (int i = 0; i < 130; i++) send_request(OP_PUT, CH_LF);
        set_echo(1);
        send_request(OP_RX, CH_LF);
        for (int i = 0; i < 20; i++) send_request(OP_RX, 8'($urandom));
        for (int i = 0; i < 40; i++) send_request(OP_TXRDY, 8'h00);
        send_request(OP_CLR, 8'h00);
    endtask

    task automatic test_random();
        logic [2:0] op;
        for (int i = 0; i < 80; i++) begin
            op = ($urandom_range(19) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(3));
            send_request(op, ($urandom_range(5) == 0) ? CH_LF : 8'($urandom));
            if ($urandom_range(150) == 0) set_echo(1'($urandom_range(1)));
        end
    endtask

    task automatic test_backpressure();
        hold_req <= 1;
        @(negedge i_clk);
        hold_req <= 0;
        for (int i = 0; i < 20; i++) send_request(OP_PUT, 8'($urandom));
    endtask

    initial begin
        m_overrun = 0; m_tx_en = 0; m_echo = 0; m_older = 0; m_newer = 0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);
        send_idle = 36; recv_idle = 68;
        test_directed();
        test_echo_escape();
        send_idle = 68; recv_idle = 36;
        test_full_queues();
        test_random();
        send_idle = 0; recv_idle = 0;
        test_backpressure();
        test_random();
        set_echo(0);
        drain_and_settle();
        if (errors == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end
endmodule

### filelist.f
+incdir+rtl
rtl/bsrq_pkg.sv
rtl/bsrq_front.sv
rtl/bsrq_back.sv
rtl/buffered_serial_rx_tx_queues.sv
rtl/bsrq_checker.sv
tb/tb_top.sv
